// ===== hdl/log_band_spectrum_averager_unit_defines.svh =====
// Assertion macros used by the log band averager controller.
`ifndef LOG_BAND_SPECTRUM_AVERAGER_UNIT_DEFINES_SVH
`define LOG_BAND_SPECTRUM_AVERAGER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LBSA_ASSERT_IMP(lbl, ck, rn, ant, con) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ant) |-> (con)) \
		else $error("lbsa assertion failed");

// next-cycle implication, disabled during reset
`define LBSA_ASSERT_NXT(lbl, ck, rn, ant, con) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ant) |=> (con)) \
		else $error("lbsa assertion failed");

`endif

// ===== hdl/lbsa_pkg.sv =====
// Shared types and constants of the log band averager.
`timescale 1ns / 1ps
package lbsa_pkg;

	localparam logic [10:0] CNT_MAX  = 11'h7FF;
	localparam logic [47:0] EDGE_MAX = 48'hFFFF_FFFF_FFFF;

	localparam logic [6:0]  NUM_BANDS_RST  = 7'd16;
	localparam logic [31:0] FIRST_EDGE_RST = 32'd30430;
	localparam logic [25:0] BAND_RATIO_RST = 26'd103872;

	typedef enum logic [1:0] {
		REG_NUM_BANDS  = 2'd0,
		REG_FIRST_EDGE = 2'd1,
		REG_BAND_RATIO = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [6:0]  num_bands;
		logic [31:0] first_edge_bins;
		logic [25:0] band_ratio;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic div_start;
		logic edge_hi;
		logic edge_lo;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic close;
		logic div_done;
		logic out_busy;
	} dp_status_t;

endpackage

// ===== hdl/lbsa_bin_if.sv =====
// Input channel: one FFT bin per item.
`timescale 1ns / 1ps
interface lbsa_bin_if;
	logic        valid;
	logic        ready;
	logic [15:0] magnitude;
	logic        channel;
	logic        last_bin;

	modport source (output valid, magnitude, channel, last_bin, input ready);
	modport sink (input valid, magnitude, channel, last_bin, output ready);
endinterface

// ===== hdl/lbsa_band_if.sv =====
// Output channel: one band average per item.
`timescale 1ns / 1ps
interface lbsa_band_if;
	logic        valid;
	logic        ready;
	logic [5:0]  band_index;
	logic        band_channel;
	logic [15:0] average;
	logic        end_of_frame;
	logic        truncated;

	modport source (output valid, band_index, band_channel, average, end_of_frame, truncated,
		input ready);
	modport sink (input valid, band_index, band_channel, average, end_of_frame, truncated,
		output ready);
endinterface

// ===== hdl/lbsa_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lbsa_divider #(
	parameter int DVD_W = 40,
	parameter int DVS_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	localparam int CW = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== hdl/lbsa_datapath.sv =====
// Datapath: band accumulation, edge update, divider and output register.
`timescale 1ns / 1ps
module lbsa_datapath import lbsa_pkg::*; #(
	parameter int MAX_BANDS = 64,
	parameter int MAG_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  ctrl_cmd_t   cmd,
	output dp_status_t  status,
	input  logic [15:0] magnitude,
	input  logic        channel,
	input  logic        last_bin,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  band_index,
	output logic        band_channel,
	output logic [15:0] average,
	output logic        end_of_frame,
	output logic        truncated
);
	localparam int MAG_W = (MAG_BITS < 16) ? MAG_BITS : 16;
	localparam int SUM_W = MAG_W + 24;
	localparam int CB_W  = $clog2(MAX_BANDS + 1);

	logic [10:0]      bin_q;
	logic [CB_W-1:0]  cur_q;
	logic [SUM_W-1:0] sum_q;
	logic [10:0]      cnt_q;
	logic [47:0]      edge_q;
	logic [57:0]      prod_hi_q;
	logic             frame_end_q;

	logic [5:0]       res_index_q;
	logic             res_chan_q;
	logic             res_eof_q;
	logic             res_trunc_q;

	logic             out_valid_q;
	logic [5:0]       out_index_q;
	logic             out_chan_q;
	logic [15:0]      out_avg_q;
	logic             out_eof_q;
	logic             out_trunc_q;

	logic [8:0]       bands9;
	logic [8:0]       cur9;
	logic             band_open;
	logic [SUM_W-1:0] sum_new;
	logic [10:0]      cnt_new;
	logic [11:0]      bin_p1;
	logic             reached;
	logic             close;
	logic [41:0]      prod_lo;
	logic [58:0]      edge_sum;
	logic [SUM_W-1:0] quotient;
	logic             div_done;

	assign bands9    = (9'(cfg.num_bands) > 9'(MAX_BANDS)) ? 9'(MAX_BANDS) : 9'(cfg.num_bands);
	assign cur9      = 9'(cur_q);
	assign band_open = (bin_q != 11'd0) && (cur9 < bands9);
	assign sum_new   = sum_q + SUM_W'(magnitude[MAG_W-1:0]);
	assign cnt_new   = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 11'd1;
	assign bin_p1    = 12'(bin_q) + 12'd1;
	assign reached   = {8'd0, bin_p1, 28'd0} >> 12 >= edge_q;
	assign close     = band_open && (reached || last_bin);

	assign prod_lo  = 42'(edge_q[15:0]) * 42'(cfg.band_ratio);
	assign edge_sum = 59'(prod_hi_q) + 59'(prod_lo[41:16]);

	lbsa_divider #(
		.DVD_W (SUM_W),
		.DVS_W (11)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_new),
		.divisor  (cnt_new),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q       <= '0;
			cur_q       <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			edge_q      <= 48'(FIRST_EDGE_RST);
			frame_end_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (band_open) begin
					if (close) begin
						sum_q <= '0;
						cnt_q <= '0;
						cur_q <= cur_q + CB_W'(1);
						frame_end_q <= last_bin;
					end else begin
						sum_q <= sum_new;
						cnt_q <= cnt_new;
					end
				end
				if (last_bin) begin
					bin_q  <= '0;
					cur_q  <= '0;
					sum_q  <= '0;
					cnt_q  <= '0;
					edge_q <= 48'(cfg.first_edge_bins);
				end else if (bin_q != CNT_MAX) begin
					bin_q <= bin_q + 11'd1;
				end
			end
			if (cmd.edge_lo && !frame_end_q) begin
				edge_q <= (edge_sum > 59'(EDGE_MAX)) ? EDGE_MAX : edge_sum[47:0];
			end
		end
	end

	// result fields captured when a band closes
	always_ff @(posedge clk) begin
		if (cmd.accept && close) begin
			res_index_q <= 6'(cur_q);
			res_chan_q  <= channel;
			res_eof_q   <= last_bin || ((cur9 + 9'd1) == bands9);
			res_trunc_q <= !reached;
		end
		if (cmd.edge_hi) begin
			prod_hi_q <= 58'(edge_q[47:16]) * 58'(cfg.band_ratio);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_index_q <= res_index_q;
			out_chan_q  <= res_chan_q;
			out_avg_q   <= quotient[15:0];
			out_eof_q   <= res_eof_q;
			out_trunc_q <= res_trunc_q;
		end
	end

	assign status.close    = close;
	assign status.div_done = div_done;
	assign status.out_busy = out_valid_q && !out_ready;

	assign out_valid    = out_valid_q;
	assign band_index   = out_index_q;
	assign band_channel = out_chan_q;
	assign average      = out_avg_q;
	assign end_of_frame = out_eof_q;
	assign truncated    = out_trunc_q;
endmodule

// ===== hdl/lbsa_ctrl.sv =====
// Controller: sequences edge update, division and result hand-off.
`timescale 1ns / 1ps
`include "log_band_spectrum_averager_unit_defines.svh"
module lbsa_ctrl import lbsa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);
	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_EDGE_HI  = 5'b00010,
		ST_EDGE_LO  = 5'b00100,
		ST_DIV_WAIT = 5'b01000,
		ST_PUT      = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_ready && in_valid;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && status.close) state_d = ST_EDGE_HI;
			end
			ST_EDGE_HI:  state_d = ST_EDGE_LO;
			ST_EDGE_LO:  state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (status.div_done) state_d = ST_PUT;
			end
			ST_PUT: begin
				if (!status.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.accept    = accept;
	assign cmd.div_start = accept && status.close;
	assign cmd.edge_hi   = (state_q == ST_EDGE_HI);
	assign cmd.edge_lo   = (state_q == ST_EDGE_LO);
	assign cmd.load_out  = (state_q == ST_PUT) && !status.out_busy;

	`LBSA_ASSERT_NXT(a_close_starts_edge, clk, arst_n, accept && status.close, state_q == ST_EDGE_HI)
	`LBSA_ASSERT_IMP(a_done_in_wait, clk, arst_n, status.div_done, state_q == ST_DIV_WAIT)
	`LBSA_ASSERT_NXT(a_put_to_idle, clk, arst_n, cmd.load_out, state_q == ST_IDLE)
endmodule

// ===== hdl/log_band_spectrum_averager_unit.sv =====
// Top level: APB register file, controller and datapath of the log band averager.
// A bin that leaves its band open is taken without stalling; such bins stream at one per cycle.
// A bin that closes a band holds the input through the edge update, the division
// (one quotient bit per cycle) and the hand-off of its average to the output register.
// The result register lets the next bins enter while a band average waits to be taken.
// Asynchronous active-low reset clears the registers to their defaults and all frame state.
`timescale 1ns / 1ps
module log_band_spectrum_averager_unit import lbsa_pkg::*; #(
	parameter int MAX_BANDS = 64,
	parameter int MAG_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	lbsa_bin_if.sink    bin_in,
	lbsa_band_if.source band_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	cfg_t       cfg_q;
	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       in_ready;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_bands       <= NUM_BANDS_RST;
			cfg_q.first_edge_bins <= FIRST_EDGE_RST;
			cfg_q.band_ratio      <= BAND_RATIO_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_NUM_BANDS:  cfg_q.num_bands       <= pwdata[6:0];
				REG_FIRST_EDGE: cfg_q.first_edge_bins <= pwdata;
				REG_BAND_RATIO: cfg_q.band_ratio      <= pwdata[25:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_NUM_BANDS:  prdata = 32'(cfg_q.num_bands);
			REG_FIRST_EDGE: prdata = cfg_q.first_edge_bins;
			REG_BAND_RATIO: prdata = 32'(cfg_q.band_ratio);
			default:        prdata = 32'd0;
		endcase
	end

	lbsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bin_in.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	assign bin_in.ready = in_ready;

	lbsa_datapath #(
		.MAX_BANDS (MAX_BANDS),
		.MAG_BITS  (MAG_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.status       (status),
		.magnitude    (bin_in.magnitude),
		.channel      (bin_in.channel),
		.last_bin     (bin_in.last_bin),
		.out_valid    (band_out.valid),
		.out_ready    (band_out.ready),
		.band_index   (band_out.band_index),
		.band_channel (band_out.band_channel),
		.average      (band_out.average),
		.end_of_frame (band_out.end_of_frame),
		.truncated    (band_out.truncated)
	);
endmodule
